### rtl/core/ramt_pkg.sv
`timescale 1ns / 1ps
package ramt_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int TREE_NODES   = 4 * MAX_ELEMENTS;
    localparam int NODE_AW      = $clog2(TREE_NODES);
    localparam int IDX_W        = 11;
    localparam int STACK_DEPTH  = 16;
    localparam int STACK_AW     = $clog2(STACK_DEPTH);
    localparam int SP_W         = STACK_AW + 1;

    localparam logic signed [63:0] EMPTY_SENTINEL = -64'sd1000000007;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // input word
    typedef struct packed {
        logic               command;
        logic [10:0]        range_first;
        logic [10:0]        range_last;
        logic signed [31:0] add_amount;
    } t_cmd;

    // result word
    typedef struct packed {
        logic signed [63:0] range_maximum;
        logic               empty_range;
    } t_res;

    // one level of the tree walk
    typedef struct packed {
        logic [NODE_AW-1:0] id;
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic [1:0]         step;
    } t_frame;

    // 64-bit add clamped at the signed limits
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            s = b[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

endpackage

### rtl/core/range_add_range_max_tree.sv
`timescale 1ns / 1ps
// Range-add / range-max tree over up to 1024 signed 64-bit elements. A word is taken when
// i_start is high and o_busy low; o_busy stays high until the word is finished. The walk is
// run by one sequencer over two node memories (maximum and pending sum, each with one read
// and one write port) and one shared saturating 64-bit adder. A query gives its result as a
// one-cycle o_res_valid strobe as it finishes; the receiver cannot stall it, and an add gives
// none. After reset the node memories are cleared with o_busy high. element_count may be
// written on the cfg channel at any time the block is idle; o_cfg_ready is always high.
module range_add_range_max_tree (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  ramt_pkg::t_cmd  i_cmd,
    output logic            o_res_valid,
    output ramt_pkg::t_res  o_res,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [10:0]     i_cfg_data
);
    import ramt_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FRAME = 4'd2;
    localparam logic [3:0] S_E0    = 4'd3;
    localparam logic [3:0] S_E1    = 4'd4;
    localparam logic [3:0] S_SA    = 4'd5;
    localparam logic [3:0] S_SB    = 4'd6;
    localparam logic [3:0] S_SC    = 4'd7;
    localparam logic [3:0] S_POST  = 4'd8;
    localparam logic [3:0] S_R0    = 4'd9;
    localparam logic [3:0] S_R1    = 4'd10;
    localparam logic [3:0] S_R2    = 4'd11;
    localparam logic [3:0] S_POP   = 4'd12;

    localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_ELEMENTS);

    logic [3:0]          r_state, n_state;
    logic [NODE_AW-1:0]  r_clr, n_clr;
    logic [IDX_W-1:0]    r_ec, n_ec;
    t_cmd                r_cmd, n_cmd;
    t_frame              r_cur, n_cur;
    t_frame              r_stack [STACK_DEPTH];
    logic [SP_W-1:0]     r_sp, n_sp;
    logic signed [63:0]  r_p, n_p;
    logic signed [63:0]  r_nmv, n_nmv;
    logic signed [63:0]  r_a, n_a;
    logic                r_second, n_second;
    logic signed [63:0]  r_best, n_best;
    logic                r_found, n_found;
    logic                r_res_valid, n_res_valid;
    t_res                r_res, n_res;

    // node memories
    logic signed [63:0]  nm_mem [TREE_NODES];
    logic signed [63:0]  pd_mem [TREE_NODES];
    logic signed [63:0]  r_nm_q, r_pd_q;
    logic [NODE_AW-1:0]  rd_addr;
    logic                nm_we, pd_we;
    logic [NODE_AW-1:0]  nm_wa, pd_wa;
    logic signed [63:0]  nm_wd, pd_wd;

    logic                push;
    t_frame              push_frame;

    logic signed [63:0]  add_a, add_b, add_s;
    logic [IDX_W:0]      lo_hi_sum;
    logic [IDX_W-1:0]    mid;
    logic [NODE_AW-1:0]  child_l, child_r;
    logic                disjoint, covered;
    logic [SP_W-1:0]     sp_dec;
    logic [IDX_W-1:0]    n_clamped;

    // shared saturating adder
    assign add_s = sat_add(add_a, add_b);

    assign lo_hi_sum = {1'b0, r_cur.lo} + {1'b0, r_cur.hi};
    assign mid       = lo_hi_sum[IDX_W:1];
    assign child_l   = {r_cur.id[NODE_AW-2:0], 1'b0};
    assign child_r   = {r_cur.id[NODE_AW-2:0], 1'b1};
    assign disjoint  = (r_cmd.range_last < r_cur.lo) || (r_cur.hi < r_cmd.range_first);
    assign covered   = (r_cmd.range_first <= r_cur.lo) && (r_cur.hi <= r_cmd.range_last);
    assign sp_dec    = r_sp - SP_W'(1);
    assign n_clamped = (r_ec == '0) ? IDX_W'(1) : ((r_ec > MAX_N) ? MAX_N : r_ec);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ec        = r_ec;
        n_cmd       = r_cmd;
        n_cur       = r_cur;
        n_sp        = r_sp;
        n_p         = r_p;
        n_nmv       = r_nmv;
        n_a         = r_a;
        n_second    = r_second;
        n_best      = r_best;
        n_found     = r_found;
        n_res_valid = 1'b0;
        n_res       = r_res;
        rd_addr     = r_cur.id;
        nm_we       = 1'b0;
        pd_we       = 1'b0;
        nm_wa       = r_cur.id;
        pd_wa       = r_cur.id;
        nm_wd       = add_s;
        pd_wd       = add_s;
        add_a       = r_pd_q;
        add_b       = r_p;
        push        = 1'b0;
        push_frame  = r_cur;

        if (i_cfg_valid) begin
            n_ec = i_cfg_data;
        end

        unique case (r_state)
            S_CLEAR: begin
                nm_we = 1'b1;
                pd_we = 1'b1;
                nm_wa = r_clr;
                pd_wa = r_clr;
                nm_wd = '0;
                pd_wd = '0;
                n_clr = r_clr + NODE_AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_cur   = '{id: NODE_AW'(1), lo: IDX_W'(1), hi: n_clamped, step: 2'd0};
                    n_sp    = '0;
                    n_found = 1'b0;
                    n_best  = '0;
                    n_state = S_FRAME;
                end
            end
            S_FRAME: begin
                unique case (r_cur.step)
                    2'd0: n_state = S_E0;
                    2'd1: begin
                        // left side done, go right
                        push            = 1'b1;
                        push_frame.step = 2'd2;
                        n_sp            = r_sp + SP_W'(1);
                        n_cur = '{id: child_r, lo: mid + IDX_W'(1), hi: r_cur.hi, step: 2'd0};
                        n_state = S_FRAME;
                    end
                    2'd2: n_state = (r_cmd.command == CMD_ADD) ? S_R0 : S_POP;
                    default: n_state = S_POP;
                endcase
            end
            S_E0: begin
                rd_addr = r_cur.id;
                n_state = S_E1;
            end
            S_E1: begin
                n_p      = r_pd_q;
                n_nmv    = r_nm_q;
                n_second = 1'b0;
                n_state  = S_SA;
            end
            S_SA: begin
                // apply pending sum to the node
                if (r_p == '0) begin
                    n_state = S_POST;
                end else begin
                    add_a = r_nmv;
                    add_b = r_p;
                    nm_we = 1'b1;
                    nm_wd = add_s;
                    n_nmv = add_s;
                    pd_we = 1'b1;
                    pd_wd = '0;
                    if (r_cur.lo != r_cur.hi && !r_cur.id[NODE_AW-1]) begin
                        rd_addr = child_l;
                        n_state = S_SB;
                    end else begin
                        n_state = S_POST;
                    end
                end
            end
            S_SB: begin
                // pass it to the left child
                pd_we   = 1'b1;
                pd_wa   = child_l;
                rd_addr = child_r;
                n_state = S_SC;
            end
            S_SC: begin
                // and to the right child
                pd_we   = 1'b1;
                pd_wa   = child_r;
                n_state = S_POST;
            end
            S_POST: begin
                priority if (r_second || disjoint) begin
                    n_state = S_POP;
                end else if (covered) begin
                    if (r_cmd.command == CMD_QUERY) begin
                        if (!r_found || r_nmv > r_best) begin
                            n_best = r_nmv;
                        end
                        n_found = 1'b1;
                        n_state = S_POP;
                    end else begin
                        n_p      = {{32{r_cmd.add_amount[31]}}, r_cmd.add_amount};
                        n_second = 1'b1;
                        n_state  = S_SA;
                    end
                end else if (r_cur.id[NODE_AW-1]) begin
                    n_state = S_POP;
                end else begin
                    // descend left
                    push            = 1'b1;
                    push_frame.step = 2'd1;
                    n_sp            = r_sp + SP_W'(1);
                    n_cur   = '{id: child_l, lo: r_cur.lo, hi: mid, step: 2'd0};
                    n_state = S_FRAME;
                end
            end
            S_R0: begin
                rd_addr = child_l;
                n_state = S_R1;
            end
            S_R1: begin
                n_a     = r_nm_q;
                rd_addr = child_r;
                n_state = S_R2;
            end
            S_R2: begin
                // rebuild the node maximum from its children
                nm_we   = 1'b1;
                nm_wd   = (r_a > r_nm_q) ? r_a : r_nm_q;
                n_state = S_POP;
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_res_valid = (r_cmd.command == CMD_QUERY);
                    n_res.range_maximum = r_found ? r_best : EMPTY_SENTINEL;
                    n_res.empty_range   = !r_found;
                    n_state = S_IDLE;
                end else begin
                    n_cur   = r_stack[sp_dec[STACK_AW-1:0]];
                    n_sp    = sp_dec;
                    n_state = S_FRAME;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ec        <= MAX_N;
            r_sp        <= '0;
            r_res_valid <= 1'b0;
            r_second    <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ec        <= n_ec;
            r_sp        <= n_sp;
            r_res_valid <= n_res_valid;
            r_second    <= n_second;
            r_found     <= n_found;
        end
        r_cmd  <= n_cmd;
        r_cur  <= n_cur;
        r_p    <= n_p;
        r_nmv  <= n_nmv;
        r_a    <= n_a;
        r_best <= n_best;
        r_res  <= n_res;
    end

    // walk stack
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[r_sp[STACK_AW-1:0]] <= push_frame;
        end
    end

    // node maximum memory
    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            nm_mem[nm_wa] <= nm_wd;
        end
        r_nm_q <= nm_mem[rd_addr];
    end

    // pending sum memory
    always_ff @(posedge i_clk) begin
        if (pd_we) begin
            pd_mem[pd_wa] <= pd_wd;
        end
        r_pd_q <= pd_mem[rd_addr];
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

### rtl/core/ramt_checker.sv
`timescale 1ns / 1ps
module ramt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_start,
    input logic            o_busy,
    input logic            o_res_valid,
    input ramt_pkg::t_res  o_res
);
    import ramt_pkg::*;

    // clearing pass follows reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy)
        else $error("block not busy after reset");

    // accepted word keeps the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after accepting a word");

    // a result is a single-cycle strobe
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    // empty result carries the sentinel
    a_empty_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.empty_range) |-> (o_res.range_maximum == EMPTY_SENTINEL))
        else $error("empty result without sentinel");

    // result shows as the block goes idle
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !o_busy)
        else $error("result shown while busy");

endmodule

bind range_add_range_max_tree ramt_checker u_ramt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
